[rtl/mbps_pkg.sv]
// Shared types and constants for the masked byte pattern search core.
package mbps_pkg;

	localparam int CFG_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int POS_W = 15;
	localparam int LEN_W = 6;
	localparam int MASK_W = 32;
	localparam int PAT_WORDS = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO     = 3'd0,
		REG_PAT_MID_LO = 3'd1,
		REG_PAT_MID_HI = 3'd2,
		REG_PAT_HI     = 3'd3,
		REG_CARE_MASK  = 3'd4,
		REG_PAT_LEN    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] pat;
		logic       care;
	} cell_ctl_t;

	typedef struct packed {
		logic             match;
		logic [POS_W-1:0] match_offset;
		logic             any_match;
		logic             end_of_buffer;
	} result_t;

endpackage

[rtl/mbps_cell.sv]
// One window cell: holds a byte of the recent history and compares its incoming byte.
module mbps_cell (
	input  logic                 clk,
	input  logic                 shift,
	input  logic [7:0]           d,
	input  mbps_pkg::cell_ctl_t  ctl,
	output logic [7:0]           q,
	output logic                 hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d;
		end
	end

	assign q   = byte_q;
	assign hit = !ctl.care || (d == ctl.pat);

endmodule

[rtl/mbps_out_buf.sv]
// Result register with a skid stage between the search logic and the output channel.
module mbps_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mbps_pkg::result_t   push_data,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output mbps_pkg::result_t   out_data
);

	logic              out_v_q;
	logic              skid_v_q;
	mbps_pkg::result_t out_q;
	mbps_pkg::result_t skid_q;
	logic              take;

	assign take = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

[rtl/masked_byte_pattern_search_core.sv]
// Masked byte pattern search core: byte window cell chain, position tracking, result buffer.
// Each accepted input beat produces one result beat, registered in the result buffer.
// Throughput: one byte per cycle while in_stall is low; the cell chain compares the whole window combinationally.
// Input stalls only while both the result register and its skid stage are full.
// Reset (arst_n, async): position, any-match flag, handshake state cleared;
// care mask to all ones, pattern length to one, pattern bytes to zero.
module masked_byte_pattern_search_core #(
	parameter int MAX_PATTERN_BYTES = 32,
	parameter int BUFFER_BYTES = 32768
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbps_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        data_byte,
	input  logic                              last_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              match,
	output logic [mbps_pkg::POS_W-1:0]        match_offset,
	output logic                              any_match,
	output logic                              end_of_buffer
);

	localparam int LEN_CAP = (MAX_PATTERN_BYTES < 32) ? MAX_PATTERN_BYTES : 32;
	localparam int POS_MAX = ((BUFFER_BYTES - 1) < 32767) ? (BUFFER_BYTES - 1) : 32767;

	logic [mbps_pkg::PAT_WORDS-1:0][mbps_pkg::CFG_W-1:0] pat_q;
	logic [mbps_pkg::MASK_W-1:0] care_q;
	logic [mbps_pkg::LEN_W-1:0]  len_q;
	logic [mbps_pkg::POS_W-1:0]  pos_q;
	logic                        found_q;

	logic                        accept;
	logic [mbps_pkg::LEN_W-1:0]  eff_len;
	logic [mbps_pkg::LEN_W-1:0]  len_m1;
	logic [7:0]                  chain [LEN_CAP];
	logic [LEN_CAP-1:0]          cell_hit;
	logic                        hit;
	mbps_pkg::result_t           res;
	mbps_pkg::result_t           out_res;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			care_q <= '1;
			len_q  <= mbps_pkg::LEN_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mbps_pkg::REG_PAT_LO:     pat_q[0] <= cfg_wdata;
				mbps_pkg::REG_PAT_MID_LO: pat_q[1] <= cfg_wdata;
				mbps_pkg::REG_PAT_MID_HI: pat_q[2] <= cfg_wdata;
				mbps_pkg::REG_PAT_HI:     pat_q[3] <= cfg_wdata;
				mbps_pkg::REG_CARE_MASK:  care_q <= cfg_wdata[mbps_pkg::MASK_W-1:0];
				mbps_pkg::REG_PAT_LEN:    len_q <= cfg_wdata[mbps_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_q == '0) begin
			eff_len = mbps_pkg::LEN_W'(1);
		end else if (len_q > mbps_pkg::LEN_W'(LEN_CAP)) begin
			eff_len = mbps_pkg::LEN_W'(LEN_CAP);
		end else begin
			eff_len = len_q;
		end
	end

	assign len_m1 = eff_len - mbps_pkg::LEN_W'(1);
	assign accept = in_valid && !in_stall;
	assign chain[0] = data_byte;

	// cell k sees the byte of age k; it is checked against pattern byte len-1-k
	for (genvar k = 0; k < LEN_CAP; k++) begin : g_cell
		logic [mbps_pkg::LEN_W-1:0] sel;
		logic [4:0]                 j;
		mbps_pkg::cell_ctl_t        ctl;

		assign sel = len_m1 - mbps_pkg::LEN_W'(k);
		assign j   = sel[4:0];
		assign ctl.care = (mbps_pkg::LEN_W'(k) < eff_len) && care_q[j];
		assign ctl.pat  = pat_q[j[4:3]][{j[2:0], 3'b000} +: 8];

		if (k < LEN_CAP - 1) begin : g_mid
			mbps_cell u_cell (
				.clk   (clk),
				.shift (accept),
				.d     (chain[k]),
				.ctl   (ctl),
				.q     (chain[k+1]),
				.hit   (cell_hit[k])
			);
		end else begin : g_end
			mbps_cell u_cell (
				.clk   (clk),
				.shift (accept),
				.d     (chain[k]),
				.ctl   (ctl),
				.q     (),
				.hit   (cell_hit[k])
			);
		end
	end

	assign hit = (&cell_hit) && (pos_q >= mbps_pkg::POS_W'(len_m1));

	always_comb begin
		res.match         = hit;
		res.match_offset  = hit ? (pos_q - mbps_pkg::POS_W'(len_m1)) : '0;
		res.any_match     = found_q || hit;
		res.end_of_buffer = last_byte;
	end

	// buffer position and any-match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			found_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q   <= '0;
				found_q <= 1'b0;
			end else begin
				found_q <= found_q || hit;
				if (pos_q < mbps_pkg::POS_W'(POS_MAX)) begin
					pos_q <= pos_q + mbps_pkg::POS_W'(1);
				end
			end
		end
	end

	mbps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign match         = out_res.match;
	assign match_offset  = out_res.match_offset;
	assign any_match     = out_res.any_match;
	assign end_of_buffer = out_res.end_of_buffer;

`ifndef SYNTHESIS
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty result register");

	a_last_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> (pos_q == '0) && !found_q)
		else $error("position or flag not cleared after last beat");

	a_match_sets_any: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match |-> any_match)
		else $error("match without any_match");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !match |-> (match_offset == '0))
		else $error("nonzero offset without match");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= mbps_pkg::POS_W'(POS_MAX))
		else $error("position beyond saturation limit");
`endif

endmodule
